// ===== design/fixed_point_alu_macros.svh =====
// Assertion macros for the fixed-point ALU top level.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define FPA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fixed-point ALU check failed");

// Next-cycle implication, sampled on clk and masked during reset.
`define FPA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fixed-point ALU check failed");

`endif

// ===== design/fpa_pkg.sv =====
// Shared constants, types and saturation helpers for the fixed-point ALU.
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int WORD_BITS = 32;
	localparam int FIELD_BITS = 32;
	localparam int EFF_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_ADD = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV = 4'd3;
	localparam logic [OP_W-1:0] OP_MAX = 4'd4;
	localparam logic [OP_W-1:0] OP_MIN = 4'd5;
	localparam logic [OP_W-1:0] OP_INC = 4'd6;
	localparam logic [OP_W-1:0] OP_DEC = 4'd7;
	localparam logic [OP_W-1:0] OP_I2F = 4'd8;
	localparam logic [OP_W-1:0] OP_F2I = 4'd9;

	localparam int ST_W = 2;
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_SAT = 2'd1;
	localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

	localparam int NUM_W = EFF_BITS + FRAC_BITS;
	localparam int DIV_STEP_BITS = 4;
	localparam int DIV_STEPS = (NUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int QUO_W = DIV_STEPS * DIV_STEP_BITS;
	localparam int PROD_W = 2 * EFF_BITS;
	localparam int MRND_W = PROD_W - FRAC_BITS + 1;
	localparam int MAG_W = (MRND_W > QUO_W + 1) ? MRND_W : QUO_W + 1;
	localparam int SUM_W = EFF_BITS + 2;

	localparam logic [EFF_BITS-1:0] WORD_MIN = {1'b1, {(EFF_BITS-1){1'b0}}};
	localparam logic [EFF_BITS-1:0] WORD_MAX = ~WORD_MIN;

	typedef logic signed [EFF_BITS-1:0] word_t;

	typedef struct packed {
		logic [EFF_BITS-1:0] value;
		logic sat;
	} satres_t;

	typedef struct packed {
		logic [QUO_W-1:0] nq;
		logic [EFF_BITS-1:0] rem;
	} div_state_t;

	typedef struct packed {
		logic valid;
		logic [OP_W-1:0] op;
		logic [EFF_BITS-1:0] res;
		logic [ST_W-1:0] status;
		logic gt;
		logic lt;
		logic eq;
		logic neg;
		logic div0;
	} stage_t;

	// Clamp a sign and magnitude pair to the word range.
	function automatic satres_t sat_mag(input logic [MAG_W-1:0] m, input logic neg);
		logic [MAG_W-1:0] lim;
		logic [MAG_W-1:0] neg_m;
		satres_t r;
		lim = MAG_W'(1) << (EFF_BITS - 1);
		neg_m = ~m + MAG_W'(1);
		if (neg) begin
			if (m > lim) begin
				r.value = WORD_MIN;
				r.sat = 1'b1;
			end else begin
				r.value = neg_m[EFF_BITS-1:0];
				r.sat = 1'b0;
			end
		end else begin
			if (m >= lim) begin
				r.value = WORD_MAX;
				r.sat = 1'b1;
			end else begin
				r.value = m[EFF_BITS-1:0];
				r.sat = 1'b0;
			end
		end
		return r;
	endfunction

	// Clamp a two's complement value two bits wider than a word.
	function automatic satres_t sat_sum(input logic [SUM_W-1:0] v);
		satres_t r;
		if ((v[SUM_W-1] == v[SUM_W-2]) && (v[SUM_W-2] == v[SUM_W-3])) begin
			r.value = v[EFF_BITS-1:0];
			r.sat = 1'b0;
		end else begin
			r.value = v[SUM_W-1] ? WORD_MIN : WORD_MAX;
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== design/fpa_divider.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage.
module fpa_divider (
	input  logic clk,
	input  logic en,
	input  logic [fpa_pkg::NUM_W-1:0] num,
	input  logic [fpa_pkg::EFF_BITS-1:0] den,
	output logic [fpa_pkg::QUO_W-1:0] quo,
	output logic [fpa_pkg::EFF_BITS-1:0] rem,
	output logic [fpa_pkg::EFF_BITS-1:0] den_out
);
	import fpa_pkg::*;

	function automatic div_state_t div_step(input div_state_t s, input logic [EFF_BITS-1:0] d);
		div_state_t r;
		logic [EFF_BITS:0] t;
		r = s;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			t = {r.rem, r.nq[QUO_W-1]};
			r.nq = r.nq << 1;
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				r.nq[0] = 1'b1;
			end
			r.rem = t[EFF_BITS-1:0];
		end
		return r;
	endfunction

	div_state_t st_s [1:DIV_STEPS];
	logic [EFF_BITS-1:0] dv_s [1:DIV_STEPS];
	div_state_t st_in;

	assign st_in.nq = QUO_W'(num);
	assign st_in.rem = '0;

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[1] <= div_step(st_in, den);
			dv_s[1] <= den;
		end
	end

	for (genvar k = 2; k <= DIV_STEPS; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= div_step(st_s[k-1], dv_s[k-1]);
				dv_s[k] <= dv_s[k-1];
			end
		end
	end

	assign quo = st_s[DIV_STEPS].nq;
	assign rem = st_s[DIV_STEPS].rem;
	assign den_out = dv_s[DIV_STEPS];

endmodule

// ===== design/fixed_point_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
// The ALU takes one beat per cycle while in_ready is high and returns one result beat for each
// request, in order; the pipeline holds while an output beat waits for out_ready. The divider
// resolves four quotient bits per pipeline stage over the 40-bit shifted dividend, and every
// other operation rides alongside it so that results leave in order. Multiply and divide round
// to nearest with ties away from zero, overflow saturates with status 1, and divide by zero
// gives status 2.
`include "fixed_point_alu_macros.svh"

module fixed_point_alu (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [3:0] req_type,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] result,
	output logic [1:0] status,
	output logic a_greater,
	output logic a_less,
	output logic a_equal
);
	import fpa_pkg::*;

	// The whole pipeline advances together; it holds only when the output beat is stuck.
	logic out_valid_q;
	logic pipe_en;
	assign pipe_en = !out_valid_q || out_ready;
	assign in_ready = pipe_en;

	// Stage 1: decode, compares, the operations that finish in this stage and operand magnitudes.
	word_t a_w, b_w;
	logic [SUM_W-1:0] a_x, b_x;
	logic [EFF_BITS-1:0] mag_a, mag_b;
	logic [FRAC_BITS:0] a_top;
	satres_t add_r, sub_r, inc_r, dec_r;
	stage_t s1_next;

	assign a_w = word_t'(operand_a[EFF_BITS-1:0]);
	assign b_w = word_t'(operand_b[EFF_BITS-1:0]);
	assign a_x = SUM_W'(a_w);
	assign b_x = SUM_W'(b_w);
	assign mag_a = a_w[EFF_BITS-1] ? (~a_w + EFF_BITS'(1)) : a_w;
	assign mag_b = b_w[EFF_BITS-1] ? (~b_w + EFF_BITS'(1)) : b_w;
	assign a_top = a_w[EFF_BITS-1 -: FRAC_BITS+1];
	assign add_r = sat_sum(a_x + b_x);
	assign sub_r = sat_sum(a_x - b_x);
	assign inc_r = sat_sum(a_x + SUM_W'(1));
	assign dec_r = sat_sum(a_x - SUM_W'(1));

	always_comb begin
		s1_next.valid = in_valid;
		s1_next.op = req_type;
		s1_next.gt = a_w > b_w;
		s1_next.lt = a_w < b_w;
		s1_next.eq = a_w == b_w;
		s1_next.neg = a_w[EFF_BITS-1] ^ b_w[EFF_BITS-1];
		s1_next.div0 = 1'b0;
		s1_next.res = '0;
		s1_next.status = ST_OK;
		case (req_type)
			OP_ADD: begin
				s1_next.res = add_r.value;
				s1_next.status = add_r.sat ? ST_SAT : ST_OK;
			end
			OP_SUB: begin
				s1_next.res = sub_r.value;
				s1_next.status = sub_r.sat ? ST_SAT : ST_OK;
			end
			OP_INC: begin
				s1_next.res = inc_r.value;
				s1_next.status = inc_r.sat ? ST_SAT : ST_OK;
			end
			OP_DEC: begin
				s1_next.res = dec_r.value;
				s1_next.status = dec_r.sat ? ST_SAT : ST_OK;
			end
			OP_MAX: s1_next.res = (a_w > b_w) ? a_w : b_w;
			OP_MIN: s1_next.res = (a_w < b_w) ? a_w : b_w;
			OP_I2F: begin
				// The shift fits only when the bits pushed out and the new sign bit all match the sign.
				if ((&a_top) || !(|a_top)) begin
					s1_next.res = a_w << FRAC_BITS;
				end else begin
					s1_next.res = a_w[EFF_BITS-1] ? WORD_MIN : WORD_MAX;
					s1_next.status = ST_SAT;
				end
			end
			OP_F2I: s1_next.res = a_w >>> FRAC_BITS;
			OP_DIV: begin
				// A zero divisor is settled here; the divider result is then ignored.
				if (b_w == '0) begin
					s1_next.div0 = 1'b1;
					s1_next.status = ST_DIV0;
					if (a_w > 0) begin
						s1_next.res = WORD_MAX;
					end else if (a_w < 0) begin
						s1_next.res = WORD_MIN;
					end else begin
						s1_next.res = '0;
					end
				end
			end
			default: s1_next.res = '0;
		endcase
	end

	stage_t s1_q;
	logic [EFF_BITS-1:0] mag_a_s1, mag_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else if (pipe_en) begin
			s1_q <= s1_next;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			mag_a_s1 <= mag_a;
			mag_b_s1 <= mag_b;
		end
	end

	// The divider works on magnitudes; the quotient sign travels in the side stages.
	logic [QUO_W-1:0] div_quo;
	logic [EFF_BITS-1:0] div_rem, div_den;

	fpa_divider u_div (
		.clk(clk),
		.en(pipe_en),
		.num({mag_a_s1, {FRAC_BITS{1'b0}}}),
		.den(mag_b_s1),
		.quo(div_quo),
		.rem(div_rem),
		.den_out(div_den)
	);

	// Side stages keep every request aligned with the divider. Stage 2 holds the raw
	// magnitude product and stage 3 folds in the rounded, saturated multiply result.
	localparam int LAST = DIV_STEPS + 1;
	stage_t side_s [2:LAST];
	logic [PROD_W-1:0] prod_s2;
	satres_t mul_r;
	stage_t s3_next;

	assign mul_r = sat_mag(MAG_W'((({1'b0, prod_s2} + ((PROD_W+1)'(1) << (FRAC_BITS - 1)))
		>> FRAC_BITS)), side_s[2].neg);

	always_comb begin
		s3_next = side_s[2];
		if (side_s[2].op == OP_MUL) begin
			s3_next.res = mul_r.value;
			s3_next.status = mul_r.sat ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[2] <= '0;
		end else if (pipe_en) begin
			side_s[2] <= s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			prod_s2 <= PROD_W'(mag_a_s1) * PROD_W'(mag_b_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[3] <= '0;
		end else if (pipe_en) begin
			side_s[3] <= s3_next;
		end
	end

	for (genvar k = 4; k <= LAST; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[k] <= '0;
			end else if (pipe_en) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// Final stage: round the quotient up when twice the remainder reaches the divisor.
	logic div_up;
	satres_t div_r;
	logic [EFF_BITS-1:0] fin_res;
	logic [ST_W-1:0] fin_status;

	assign div_up = {div_rem, 1'b0} >= {1'b0, div_den};
	assign div_r = sat_mag(MAG_W'(div_quo) + MAG_W'(div_up), side_s[LAST].neg);

	always_comb begin
		fin_res = side_s[LAST].res;
		fin_status = side_s[LAST].status;
		if ((side_s[LAST].op == OP_DIV) && !side_s[LAST].div0) begin
			fin_res = div_r.value;
			fin_status = div_r.sat ? ST_SAT : ST_OK;
		end
	end

	logic [EFF_BITS-1:0] result_q;
	logic [ST_W-1:0] status_q;
	logic gt_q, lt_q, eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			out_valid_q <= side_s[LAST].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			result_q <= fin_res;
			status_q <= fin_status;
			gt_q <= side_s[LAST].gt;
			lt_q <= side_s[LAST].lt;
			eq_q <= side_s[LAST].eq;
		end
	end

	assign out_valid = out_valid_q;
	assign result = FIELD_BITS'(signed'(result_q));
	assign status = status_q;
	assign a_greater = gt_q;
	assign a_less = lt_q;
	assign a_equal = eq_q;

	`FPA_ASSERT_IMP(a_cmp_exclusive, out_valid_q, $onehot({gt_q, lt_q, eq_q}))
	`FPA_ASSERT_IMP(a_sat_at_bound, out_valid_q && (status_q == ST_SAT),
		(result_q == WORD_MAX) || (result_q == WORD_MIN))
	`FPA_ASSERT_NXT(a_stall_holds, !pipe_en,
		$stable(s1_q.valid) && $stable(side_s[LAST].valid) && $stable(out_valid_q))

endmodule
